// File: rtl/tpr_pkg.sv
`default_nettype none
package tpr_pkg;

  // Conversion word width and the bits of it that are used.
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned IDX_W       = 2;

  // Product (z2 - z1) * x * plate_ohms and the quotient that replaces it.
  localparam int unsigned PROD_W   = 2 * SAMPLE_BITS + CFG_W;
  localparam int unsigned CNT_W    = $clog2(PROD_W);
  localparam int unsigned RT_SHIFT = 12;
  localparam int unsigned RT_W     = PROD_W + 1 - RT_SHIFT;
  localparam logic [PROD_W:0] ROUND_ADD = (PROD_W + 1)'(2047);

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_SWAP_AXES      = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PLATE_OHMS     = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_PRESSURE_LIMIT = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_PENUP_TICKS    = IDX_W'(3);

  localparam logic [CFG_W-1:0] PRESSURE_LIMIT_RST = CFG_W'(65535);
  localparam logic [CFG_W-1:0] PENUP_TICKS_RST    = CFG_W'(50);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// File: rtl/touch_pressure_reporter.sv
// Touch pressure reporter for a four-wire resistive panel.
// Input channel (in_valid_i / in_stall_o): one transfer carries either a touch
// sample (operation_i = 0, four raw conversion words) or a timer tick
// (operation_i = 1). Output channel (out_valid_o / out_stall_i): at most one
// report per input transfer, either a touch report of the previously held point
// or a release event with zero position and pressure.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i while
// the block is idle; the user must keep to this, as the block does not enforce it.
// A sample with nonzero X and Z1 and with Z2 >= Z1 passes from its transfer
// through two passes of one shared multiplier, a restoring divider that
// retires one quotient bit per cycle, and a final step before the input is
// free again. A tick, or a sample that fails those checks, goes from its
// transfer straight to the final step. in_stall_o is high after the transfer
// until the block is back in idle, so one item is in flight at a time.
// The result sits in an output register; while the receiver stalls, it holds
// its value, and the block waits at its last step until the register is free.
// Reset clears the held point, stops the pen-up countdown and loads the
// register defaults (no axis swap, plate 0 ohms, limit 65535, 50 ticks).
`default_nettype none
module touch_pressure_reporter
  import tpr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                operation_i,
  input  wire logic [RAW_W-1:0]    x_raw_i,
  input  wire logic [RAW_W-1:0]    y_raw_i,
  input  wire logic [RAW_W-1:0]    z1_raw_i,
  input  wire logic [RAW_W-1:0]    z2_raw_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic                touching_o,
  output      logic [POS_W-1:0]    x_pos_o,
  output      logic [POS_W-1:0]    y_pos_o,
  output      logic [CFG_W-1:0]    pressure_o
);

  localparam int unsigned SB = SAMPLE_BITS;

  state_e state_q, state_d;

  logic             swap_q;
  logic [CFG_W-1:0] plate_q, limit_q, penup_q;

  logic             tick_q, tick_d;
  logic             ok_q, ok_d;
  logic [SB-1:0]    x_q, x_d, y_q, y_d, z1_q, z1_d, dz_q, dz_d;
  logic [SB-1:0]    rem_q, rem_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [POS_W-1:0] held_x_q, held_x_d, held_y_q, held_y_d;
  logic [CFG_W-1:0] held_p_q, held_p_d;
  logic [CFG_W-1:0] cd_q, cd_d;

  logic             out_valid_q, out_valid_d, out_touch_q, out_touch_d;
  logic [POS_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [CFG_W-1:0] out_p_q, out_p_d;

  logic              in_accept;
  logic [SB-1:0]     sx, sy, sz1, sz2;
  logic [2*SB-1:0]   mul_a;
  logic [CFG_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_res;
  logic [SB:0]       trial;
  logic              trial_ge;
  logic [PROD_W:0]   rt_sum;
  logic [RT_W-1:0]   rt;
  logic              rt_over;
  logic              can_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Masked and optionally exchanged sample words.
  always_comb begin
    sx  = swap_q ? y_raw_i[SB-1:0] : x_raw_i[SB-1:0];
    sy  = swap_q ? x_raw_i[SB-1:0] : y_raw_i[SB-1:0];
    sz1 = z1_raw_i[SB-1:0];
    sz2 = z2_raw_i[SB-1:0];
  end

  // The one multiplier: dz * x on the first pass, then that product * plate.
  assign mul_a   = (state_q == ST_MUL_A) ? (2*SB)'(dz_q) : prod_q[2*SB-1:0];
  assign mul_b   = (state_q == ST_MUL_A) ? CFG_W'(x_q) : plate_q;
  assign mul_res = mul_a * mul_b;

  // One restoring division step: the partial remainder always stays below z1.
  assign trial    = {rem_q, prod_q[PROD_W-1]};
  assign trial_ge = (trial >= {1'b0, z1_q});

  assign rt_sum  = {1'b0, prod_q} + ROUND_ADD;
  assign rt      = rt_sum[PROD_W:RT_SHIFT];
  assign rt_over = (rt > RT_W'(limit_q));

  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    ok_d        = ok_q;
    x_d         = x_q;
    y_d         = y_q;
    z1_d        = z1_q;
    dz_d        = dz_q;
    rem_d       = rem_q;
    prod_d      = prod_q;
    cnt_d       = cnt_q;
    held_x_d    = held_x_q;
    held_y_d    = held_y_q;
    held_p_d    = held_p_q;
    cd_d        = cd_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_touch_d = out_touch_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_p_d     = out_p_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          tick_d = (operation_i == OP_TICK);
          x_d    = sx;
          y_d    = sy;
          z1_d   = sz1;
          dz_d   = sz2 - sz1;
          rem_d  = '0;
          cnt_d  = CNT_W'(PROD_W - 1);
          ok_d   = (sx != '0) && (sz1 != '0) && (sz2 >= sz1);
          if (operation_i == OP_TICK || !((sx != '0) && (sz1 != '0) && (sz2 >= sz1))) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL_A;
          end
        end
      end
      ST_MUL_A: begin
        prod_d  = mul_res;
        state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        prod_d  = mul_res;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = trial_ge ? SB'(trial - {1'b0, z1_q}) : trial[SB-1:0];
        prod_d = {prod_q[PROD_W-2:0], trial_ge};
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_load) begin
          state_d = ST_IDLE;
          if (tick_q) begin
            if (cd_q != '0) begin
              cd_d = cd_q - CFG_W'(1);
              if (cd_q == CFG_W'(1)) begin
                out_valid_d = 1'b1;
                out_touch_d = 1'b0;
                out_x_d     = '0;
                out_y_d     = '0;
                out_p_d     = '0;
              end
            end
          end else if (ok_q && !rt_over) begin
            if (cd_q != '0) begin
              out_valid_d = 1'b1;
              out_touch_d = 1'b1;
              out_x_d     = held_x_q;
              out_y_d     = held_y_q;
              out_p_d     = held_p_q;
            end
            held_x_d = POS_W'(x_q);
            held_y_d = POS_W'(y_q);
            held_p_d = rt[CFG_W-1:0];
            cd_d     = (penup_q != '0) ? penup_q : CFG_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_p_q    <= '0;
      cd_q        <= '0;
      swap_q      <= 1'b0;
      plate_q     <= '0;
      limit_q     <= PRESSURE_LIMIT_RST;
      penup_q     <= PENUP_TICKS_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      held_x_q    <= held_x_d;
      held_y_q    <= held_y_d;
      held_p_q    <= held_p_d;
      cd_q        <= cd_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SWAP_AXES:      swap_q  <= cfg_data_i[0];
          REG_PLATE_OHMS:     plate_q <= cfg_data_i;
          REG_PRESSURE_LIMIT: limit_q <= cfg_data_i;
          REG_PENUP_TICKS:    penup_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q      <= tick_d;
    ok_q        <= ok_d;
    x_q         <= x_d;
    y_q         <= y_d;
    z1_q        <= z1_d;
    dz_q        <= dz_d;
    rem_q       <= rem_d;
    prod_q      <= prod_d;
    cnt_q       <= cnt_d;
    out_touch_q <= out_touch_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_p_q     <= out_p_d;
  end

  assign out_valid_o = out_valid_q;
  assign touching_o  = out_touch_q;
  assign x_pos_o     = out_x_q;
  assign y_pos_o     = out_y_q;
  assign pressure_o  = out_p_q;

  // The divider's partial remainder must stay below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < z1_q))
    else $error("divider remainder reached the divisor");

  // A release event carries no position and no pressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !touching_o) |-> (x_pos_o == '0 && y_pos_o == '0 && pressure_o == '0))
    else $error("release event with nonzero payload");

  // A fresh report only appears after the final step of an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> ($past(state_q) == ST_DONE))
    else $error("report loaded outside the final step");

  // A tick that finds the countdown at one leaves it at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && tick_q && can_load && cd_q == CFG_W'(1)) |=> (cd_q == '0))
    else $error("countdown did not expire on release");

endmodule
`default_nettype wire

// File: verif/pressure_report_checker.sv
`timescale 1ns / 1ps
module pressure_report_checker
  import tpr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             operation_i,
  input  logic [RAW_W-1:0] x_raw_i,
  input  logic [RAW_W-1:0] y_raw_i,
  input  logic [RAW_W-1:0] z1_raw_i,
  input  logic [RAW_W-1:0] z2_raw_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             touching_i,
  input  logic [POS_W-1:0] x_pos_i,
  input  logic [POS_W-1:0] y_pos_i,
  input  logic [CFG_W-1:0] pressure_i,
  output int               mismatches_o,
  output int               outstanding_o
);

  localparam longint unsigned ROUNDING    = 2047;
  localparam int unsigned     PRINT_LIMIT = 40;

  typedef struct packed {
    logic             touching;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [CFG_W-1:0] pressure;
  } report_t;

  report_t          expected_reports[$];
  logic             swap_axes;
  logic [CFG_W-1:0] plate_ohms;
  logic [CFG_W-1:0] pressure_limit;
  logic [CFG_W-1:0] penup_ticks;
  logic [CFG_W-1:0] countdown;
  logic [POS_W-1:0] held_x;
  logic [POS_W-1:0] held_y;
  logic [CFG_W-1:0] held_pressure;
  int               mismatches = 0;

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0d ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Works out the report, if any, that the transfer on the input channel causes.
  task automatic predict_report();
    logic [SAMPLE_BITS-1:0] sx;
    logic [SAMPLE_BITS-1:0] sy;
    logic [SAMPLE_BITS-1:0] z1;
    logic [SAMPLE_BITS-1:0] z2;
    longint unsigned        rt;
    report_t                r;
    if (operation_i == OP_TICK) begin
      if (countdown != '0) begin
        countdown = countdown - 1'b1;
        if (countdown == '0) begin
          r = '{touching: 1'b0, x: '0, y: '0, pressure: '0};
          expected_reports.push_back(r);
        end
      end
      return;
    end
    sx = x_raw_i[SAMPLE_BITS-1:0];
    sy = y_raw_i[SAMPLE_BITS-1:0];
    z1 = z1_raw_i[SAMPLE_BITS-1:0];
    z2 = z2_raw_i[SAMPLE_BITS-1:0];
    if (swap_axes) begin
      sx = y_raw_i[SAMPLE_BITS-1:0];
      sy = x_raw_i[SAMPLE_BITS-1:0];
    end
    if (sx == '0 || z1 == '0 || z2 < z1) return;
    rt = (longint'(z2) - longint'(z1)) * longint'(sx) * longint'(plate_ohms);
    rt = rt / longint'(z1);
    rt = (rt + ROUNDING) >> RT_SHIFT;
    if (rt > longint'(pressure_limit)) return;
    if (countdown != '0) begin
      r = '{touching: 1'b1, x: held_x, y: held_y, pressure: held_pressure};
      expected_reports.push_back(r);
    end
    held_x        = POS_W'(sx);
    held_y        = POS_W'(sy);
    held_pressure = CFG_W'(rt);
    countdown     = (penup_ticks != '0) ? penup_ticks : CFG_W'(1);
  endtask

  task automatic check_report();
    report_t want;
    if (expected_reports.size() == 0) begin
      flag_mismatch("report with nothing expected, touching", touching_i, 0);
      return;
    end
    want = expected_reports.pop_front();
    if (touching_i !== want.touching) flag_mismatch("touching", touching_i, want.touching);
    if (x_pos_i !== want.x) flag_mismatch("x_pos", x_pos_i, want.x);
    if (y_pos_i !== want.y) flag_mismatch("y_pos", y_pos_i, want.y);
    if (pressure_i !== want.pressure) flag_mismatch("pressure", pressure_i, want.pressure);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_axes      = 1'b0;
      plate_ohms     = '0;
      pressure_limit = PRESSURE_LIMIT_RST;
      penup_ticks    = PENUP_TICKS_RST;
      countdown      = '0;
      held_x         = '0;
      held_y         = '0;
      held_pressure  = '0;
      expected_reports.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SWAP_AXES:      swap_axes      = cfg_data_i[0];
          REG_PLATE_OHMS:     plate_ohms     = cfg_data_i;
          REG_PRESSURE_LIMIT: pressure_limit = cfg_data_i;
          REG_PENUP_TICKS:    penup_ticks    = cfg_data_i;
          default:            ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_report();
      if (out_valid_i && !out_stall_i) check_report();
    end
    mismatches_o  <= mismatches;
    outstanding_o <= expected_reports.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench
  import tpr_pkg::*;
();

  localparam int unsigned SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned PHASES         = 11;
  localparam int unsigned PHASE_ITEMS    = 130;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_BURST      = 18;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_SWAP_AXES;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic             operation = OP_SAMPLE;
  logic [RAW_W-1:0] x_raw     = '0;
  logic [RAW_W-1:0] y_raw     = '0;
  logic [RAW_W-1:0] z1_raw    = '0;
  logic [RAW_W-1:0] z2_raw    = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             touching;
  logic [POS_W-1:0] x_pos;
  logic [POS_W-1:0] y_pos;
  logic [CFG_W-1:0] pressure;
  int               mismatches;
  int               outstanding;
  int               in_idle_pct  = 10;
  int               out_idle_pct = 10;
  int               stall_left   = 0;
  int               quiet_cycles = 0;
  int               items_sent   = 0;

  touch_pressure_reporter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .operation_i (operation),
    .x_raw_i     (x_raw),
    .y_raw_i     (y_raw),
    .z1_raw_i    (z1_raw),
    .z2_raw_i    (z2_raw),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .touching_o  (touching),
    .x_pos_o     (x_pos),
    .y_pos_o     (y_pos),
    .pressure_o  (pressure)
  );

  pressure_report_checker report_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .operation_i   (operation),
    .x_raw_i       (x_raw),
    .y_raw_i       (y_raw),
    .z1_raw_i      (z1_raw),
    .z2_raw_i      (z2_raw),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .touching_i    (touching),
    .x_pos_i       (x_pos),
    .y_pos_i       (y_pos),
    .pressure_i    (pressure),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always #5 clk = ~clk;

  // The receiver stalls in bursts; how often depends on the current phase.
  always @(posedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 99) < out_idle_pct) begin
      stall_left <= $urandom_range(1, MAX_BURST);
      out_stall  <= 1'b1;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [RAW_W-1:0] raw_word(input logic [SAMPLE_BITS-1:0] v);
    logic [RAW_W-1:0] w;
    w = RAW_W'($urandom());
    w[SAMPLE_BITS-1:0] = v;
    return w;
  endfunction

  task automatic send_item(input logic op, input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                           input logic [RAW_W-1:0] z1, input logic [RAW_W-1:0] z2);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    x_raw     <= x;
    y_raw     <= y;
    z1_raw    <= z1;
    z2_raw    <= z2;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, RAW_W'($urandom()), RAW_W'($urandom()), RAW_W'($urandom()),
              RAW_W'($urandom()));
  endtask

  // A sample that passes the position and ordering checks; the pressure may
  // still exceed the limit.
  task automatic send_touch();
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
    logic [SAMPLE_BITS-1:0] z1;
    logic [SAMPLE_BITS-1:0] dz;
    x  = SAMPLE_BITS'($urandom_range(1, SAMPLE_MAX));
    y  = ($urandom_range(0, 19) == 0) ? '0 : SAMPLE_BITS'($urandom_range(1, SAMPLE_MAX));
    z1 = SAMPLE_BITS'($urandom_range(1, SAMPLE_MAX));
    case ($urandom_range(0, 3))
      0:       dz = '0;
      1:       dz = SAMPLE_BITS'($urandom_range(0, ((z1 >> 4) < (SAMPLE_MAX - z1))
                                                   ? z1 >> 4 : SAMPLE_MAX - z1));
      2:       dz = SAMPLE_BITS'($urandom_range(0, (SAMPLE_MAX - z1) >> 3));
      default: dz = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX - z1));
    endcase
    send_item(OP_SAMPLE, raw_word(x), raw_word(y), raw_word(z1), raw_word(z1 + dz));
  endtask

  task automatic send_noise();
    logic [SAMPLE_BITS-1:0] z1;
    z1 = SAMPLE_BITS'($urandom_range(2, SAMPLE_MAX));
    case ($urandom_range(0, 3))
      0: send_item(OP_SAMPLE, raw_word('0), raw_word(SAMPLE_BITS'($urandom())),
                   raw_word(SAMPLE_BITS'($urandom())), raw_word(SAMPLE_BITS'($urandom())));
      1: send_item(OP_SAMPLE, raw_word(SAMPLE_BITS'($urandom())),
                   raw_word(SAMPLE_BITS'($urandom())), raw_word('0),
                   raw_word(SAMPLE_BITS'($urandom())));
      2: send_item(OP_SAMPLE, raw_word(SAMPLE_BITS'($urandom())),
                   raw_word(SAMPLE_BITS'($urandom())), raw_word(z1),
                   raw_word(SAMPLE_BITS'($urandom_range(0, z1 - 1))));
      default: send_item(OP_SAMPLE, RAW_W'($urandom()), RAW_W'($urandom()),
                         RAW_W'($urandom()), RAW_W'($urandom()));
    endcase
  endtask

  // One pen stroke: a run of samples with the odd stray tick, then usually
  // enough ticks for the pen-up countdown to run out.
  task automatic run_stroke(input logic [CFG_W-1:0] ticks);
    int len;
    int hold;
    len  = $urandom_range(1, 12);
    hold = (ticks == '0) ? 1 : int'(ticks);
    repeat (len) begin
      if ($urandom_range(0, 5) == 0) send_tick();
      if ($urandom_range(0, 99) < 85) send_touch();
      else send_noise();
    end
    if (hold <= 40 && $urandom_range(0, 9) < 7) begin
      repeat (hold + $urandom_range(0, 2)) send_tick();
    end else begin
      repeat ($urandom_range(0, 3)) send_tick();
    end
  endtask

  task automatic write_config(input logic swap, input logic [CFG_W-1:0] plate,
                              input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] ticks);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SWAP_AXES;
    cfg_data  <= {{(CFG_W - 1){1'b0}}, swap};
    @(posedge clk);
    cfg_index <= REG_PLATE_OHMS;
    cfg_data  <= plate;
    @(posedge clk);
    cfg_index <= REG_PRESSURE_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_index <= REG_PENUP_TICKS;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every expected report, then long enough for a sample that
  // causes no report to finish.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic             swap;
    logic [CFG_W-1:0] plate;
    logic [CFG_W-1:0] limit;
    logic [CFG_W-1:0] ticks;
    int               phase_end;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: no swap, zero plate resistance, so every pressure is 0.
    send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_SAMPLE, 16'hF000, 16'h0123, 16'h0456, 16'h0789);
    send_item(OP_SAMPLE, 16'h0321, 16'h0654, 16'hF000, 16'h0800);
    send_item(OP_SAMPLE, 16'h0321, 16'h0654, 16'h0801, 16'h0800);
    send_item(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_SAMPLE, 16'hF001, 16'hF000, 16'hF001, 16'hFFFF);
    settle();

    // Swapped axes at the largest plate resistance; the first sample just fits
    // under the limit and the second, with twice the X, misses it.
    write_config(1'b1, 16'hFFFF, 16'hFFFF, 16'd2);
    send_item(OP_SAMPLE, 16'h0FFF, 16'h0001, 16'h0001, 16'h0FFF);
    send_item(OP_SAMPLE, 16'h0FFF, 16'h0002, 16'h0001, 16'h0FFF);
    send_tick();
    send_tick();
    send_tick();
    settle();

    // A zero limit admits only zero pressure, and zero pen-up ticks act as one.
    write_config(1'b0, 16'd3, 16'd0, 16'd0);
    send_item(OP_SAMPLE, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF);
    send_item(OP_SAMPLE, 16'h0FFF, 16'h0000, 16'h0001, 16'h0002);
    send_item(OP_SAMPLE, 16'h0001, 16'h0FFF, 16'h0FFF, 16'h0FFF);
    send_tick();
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          swap = 1'b0; plate = 16'hFFFF; limit = 16'hFFFF; ticks = 16'd1;
        end
        1: begin
          swap = 1'b1; plate = 16'd0; limit = 16'd0; ticks = 16'd0;
        end
        2: begin
          swap = 1'b1; plate = 16'hFFFF; limit = 16'd1; ticks = 16'hFFFF;
        end
        3: begin
          swap = 1'b0; plate = 16'd1000; limit = 16'd2000; ticks = 16'd7;
        end
        default: begin
          swap = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 2))
            0:       plate = CFG_W'($urandom_range(0, 255));
            1:       plate = CFG_W'($urandom_range(0, 4000));
            default: plate = CFG_W'($urandom());
          endcase
          limit = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(1, 65535))
                                             : CFG_W'($urandom_range(1, 3000));
          ticks = CFG_W'($urandom_range(1, 24));
        end
      endcase
      if (p == PHASES - 1) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       in_idle_pct = 0;
          1:       in_idle_pct = 10;
          default: in_idle_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0:       out_idle_pct = 0;
          1:       out_idle_pct = 10;
          default: out_idle_pct = 30;
        endcase
      end
      write_config(swap, plate, limit, ticks);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) run_stroke(ticks);
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
